### rtl/core/ptsu_pkg.sv
package ptsu_pkg;

	localparam int MAX_TASKS = 16;
	localparam int IDX_W     = $clog2(MAX_TASKS);
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);

	localparam logic [7:0] PRIO_NONE = 8'hFF;

	typedef enum logic [1:0] {
		COND_WAITING  = 2'd0,
		COND_RUNNING  = 2'd1,
		COND_SLEEPING = 2'd2,
		COND_ZOMBIE   = 2'd3
	} cond_t;

	localparam logic [2:0] REQ_CREATE = 3'd0;
	localparam logic [2:0] REQ_KILL   = 3'd1;
	localparam logic [2:0] REQ_SLEEP  = 3'd2;
	localparam logic [2:0] REQ_YIELD  = 3'd3;
	localparam logic [2:0] REQ_TICK   = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic load;
		logic setup;
		logic scan;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic accept_ok;
		logic req_sleep;
		logic req_scan;
		logic scan_last;
	} ctl_sts_t;

endpackage

### rtl/core/ptsu_ctrl.sv
module ptsu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ptsu_pkg::ctl_sts_t sts,
	output ptsu_pkg::ctl_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SETUP  = 4'b0010,
		S_SCAN   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_stall = !((state_q == S_IDLE) && sts.accept_ok);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (sts.req_sleep)
						state_d = S_SETUP;
					else if (sts.req_scan)
						state_d = S_SCAN;
					else
						state_d = S_FINISH;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last)
					state_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

### rtl/core/ptsu_dp.sv
module ptsu_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  ptsu_pkg::ctl_cmd_t cmd,
	output ptsu_pkg::ctl_sts_t sts,
	input  logic [2:0]         req_type,
	input  logic [15:0]        task_id,
	input  logic [7:0]         priority_req,
	input  logic [31:0]        sleep_ticks,
	input  logic [31:0]        now_tick,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [15:0]        new_task_id,
	output logic [15:0]        running_task_id,
	output logic               switched
);

	localparam int IW = ptsu_pkg::IDX_W;
	localparam int CW = ptsu_pkg::CNT_W;

	// task table
	logic [15:0]     id_q   [ptsu_pkg::MAX_TASKS];
	logic [7:0]      prio_q [ptsu_pkg::MAX_TASKS];
	ptsu_pkg::cond_t cond_q [ptsu_pkg::MAX_TASKS];
	logic [31:0]     wake_q [ptsu_pkg::MAX_TASKS];

	logic [CW-1:0] fill_q;
	logic [15:0]   idc_q;
	logic [IW-1:0] run_q;
	logic [15:0]   run_id_q;

	// latched request
	logic [2:0]  req_q;
	logic [15:0] kid_q;
	logic [7:0]  prio_in_q;
	logic [31:0] ticks_q;
	logic [31:0] now_q;

	// scan state
	logic [IW-1:0]   ptr_q;
	logic            found_q;
	logic [IW-1:0]   best_q;
	logic [7:0]      bprio_q;
	logic [15:0]     bid_q;
	ptsu_pkg::cond_t rcond_q;
	logic            hit_q;
	logic [IW-1:0]   hit_idx_q;

	logic            out_valid_q;
	logic [1:0]      status_q;
	logic [15:0]     new_id_q;
	logic            sw_q;

	// scan slot decode
	logic            used;
	logic            wake;
	ptsu_pkg::cond_t ce;
	logic            cand;
	logic            is_pick;
	logic [IW-1:0]   pick;
	logic [15:0]     pick_id;

	assign used = {{(CW-IW){1'b0}}, ptr_q} < fill_q;
	assign wake = (req_q == ptsu_pkg::REQ_TICK) && used &&
		(cond_q[ptr_q] == ptsu_pkg::COND_SLEEPING) && (now_q >= wake_q[ptr_q]);
	assign ce   = wake ? ptsu_pkg::COND_WAITING : cond_q[ptr_q];
	assign cand = used && (ce == ptsu_pkg::COND_WAITING) && (prio_q[ptr_q] <= bprio_q) &&
		(found_q || (prio_q[ptr_q] != ptsu_pkg::PRIO_NONE));
	assign is_pick = (req_q == ptsu_pkg::REQ_SLEEP) || (req_q == ptsu_pkg::REQ_YIELD) ||
		(req_q == ptsu_pkg::REQ_TICK);
	assign pick    = found_q ? best_q : '0;
	assign pick_id = found_q ? bid_q : 16'd0;

	assign sts.accept_ok = !out_valid_q || !out_stall;
	assign sts.req_sleep = (req_type == ptsu_pkg::REQ_SLEEP);
	assign sts.req_scan  = (req_type == ptsu_pkg::REQ_KILL) ||
		(req_type == ptsu_pkg::REQ_YIELD) || (req_type == ptsu_pkg::REQ_TICK);
	assign sts.scan_last = (ptr_q == IW'(ptsu_pkg::MAX_TASKS - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q     <= req_type;
			kid_q     <= task_id;
			prio_in_q <= priority_req;
			ticks_q   <= sleep_ticks;
			now_q     <= now_tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ptsu_pkg::MAX_TASKS; i++) begin
				id_q[i]   <= '0;
				prio_q[i] <= '0;
				cond_q[i] <= (i == 0) ? ptsu_pkg::COND_RUNNING : ptsu_pkg::COND_WAITING;
				wake_q[i] <= '0;
			end
			fill_q      <= CW'(1);
			idc_q       <= 16'd1;
			run_q       <= '0;
			run_id_q    <= '0;
			ptr_q       <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			bprio_q     <= ptsu_pkg::PRIO_NONE;
			bid_q       <= '0;
			rcond_q     <= ptsu_pkg::COND_WAITING;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ptsu_pkg::ST_OK;
			new_id_q    <= '0;
			sw_q        <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (cmd.load) begin
				ptr_q   <= '0;
				found_q <= 1'b0;
				bprio_q <= ptsu_pkg::PRIO_NONE;
				hit_q   <= 1'b0;
			end
			if (cmd.setup) begin
				cond_q[run_q] <= ptsu_pkg::COND_SLEEPING;
				wake_q[run_q] <= now_q + ticks_q;
			end
			if (cmd.scan) begin
				ptr_q <= ptr_q + IW'(1);
				if (wake)
					cond_q[ptr_q] <= ptsu_pkg::COND_WAITING;
				if (ptr_q == run_q)
					rcond_q <= ce;
				if (cand) begin
					found_q <= 1'b1;
					best_q  <= ptr_q;
					bprio_q <= prio_q[ptr_q];
					bid_q   <= id_q[ptr_q];
				end
				if (used && (id_q[ptr_q] == kid_q)) begin
					hit_q     <= 1'b1;
					hit_idx_q <= ptr_q;
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				status_q    <= ptsu_pkg::ST_OK;
				new_id_q    <= '0;
				sw_q        <= 1'b0;
				if (req_q == ptsu_pkg::REQ_CREATE) begin
					if (fill_q == CW'(ptsu_pkg::MAX_TASKS)) begin
						status_q <= ptsu_pkg::ST_FULL;
					end else begin
						id_q[fill_q[IW-1:0]]   <= idc_q;
						prio_q[fill_q[IW-1:0]] <= prio_in_q;
						cond_q[fill_q[IW-1:0]] <= ptsu_pkg::COND_WAITING;
						wake_q[fill_q[IW-1:0]] <= '0;
						fill_q   <= fill_q + CW'(1);
						new_id_q <= idc_q;
						idc_q    <= (idc_q == 16'hFFFF) ? 16'd1 : idc_q + 16'd1;
					end
				end else if (req_q == ptsu_pkg::REQ_KILL) begin
					if (hit_q)
						cond_q[hit_idx_q] <= ptsu_pkg::COND_ZOMBIE;
					else
						status_q <= ptsu_pkg::ST_NOT_FOUND;
				end else if (is_pick && (pick != run_q)) begin
					if (rcond_q == ptsu_pkg::COND_RUNNING)
						cond_q[run_q] <= ptsu_pkg::COND_WAITING;
					cond_q[pick] <= ptsu_pkg::COND_RUNNING;
					run_q    <= pick;
					run_id_q <= pick_id;
					sw_q     <= 1'b1;
				end
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign new_task_id     = new_id_q;
	assign running_task_id = run_id_q;
	assign switched        = sw_q;

`ifndef SYNTH
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(ptsu_pkg::MAX_TASKS) && fill_q != '0)
		else $error("fill count out of range");
	a_idle_id: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q == '0) |-> (run_id_q == 16'd0))
		else $error("idle slot running with nonzero id");
	a_new_id_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (new_id_q != 16'd0)) |-> (status_q == ptsu_pkg::ST_OK && !sw_q))
		else $error("create result inconsistent");
	a_sw_running: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && is_pick && (pick != run_q)) |=> (cond_q[run_q] == ptsu_pkg::COND_RUNNING))
		else $error("switched slot not running");
`endif

endmodule

### rtl/core/priority_task_scheduler_unit.sv
// Fixed-priority task table with up to ptsu_pkg::MAX_TASKS slots; slot 0 is the idle task (id 0,
// running after reset). Each input transaction is one request (create, kill, sleep, yield, tick)
// and yields exactly one result transaction. One request is in flight at a time: the table is
// walked one slot per clock. Create and unknown codes go straight from acceptance to the commit;
// kill, yield and tick first walk all MAX_TASKS slots, and sleep first parks the running task and
// then walks them. The result is registered at the commit. A new request is taken once the
// previous result has left, or in the cycle it is taken. No clearing pass after reset.
module priority_task_scheduler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [15:0] task_id,
	input  logic [7:0]  priority_req,
	input  logic [31:0] sleep_ticks,
	input  logic [31:0] now_tick,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] new_task_id,
	output logic [15:0] running_task_id,
	output logic        switched
);

	ptsu_pkg::ctl_cmd_t cmd;
	ptsu_pkg::ctl_sts_t sts;

	// sequencer: accept, park, walk, commit
	ptsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// task table, walk registers and result register
	ptsu_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.req_type        (req_type),
		.task_id         (task_id),
		.priority_req    (priority_req),
		.sleep_ticks     (sleep_ticks),
		.now_tick        (now_tick),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.new_task_id     (new_task_id),
		.running_task_id (running_task_id),
		.switched        (switched)
	);

endmodule
